FILE: sv/quadrature_decoder_with_acceleration_core_assert.svh
// Assertion macros for the quadrature decoder core.
// Both macros expect a signal named clk, and QDACC_ASSERT also rst_n, in the scope where used.
`ifndef QUADRATURE_DECODER_WITH_ACCELERATION_CORE_ASSERT_SVH
`define QUADRATURE_DECODER_WITH_ACCELERATION_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked property that is ignored while reset is asserted.
`define QDACC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qdacc assertion failed");

// Checked property that is evaluated during reset as well.
`define QDACC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("qdacc assertion failed");

`else

`define QDACC_ASSERT(lbl, prop)
`define QDACC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

FILE: sv/qdacc_pkg.sv
`default_nettype none

package qdacc_pkg;

    localparam int DELTA_WIDTH     = 16;
    localparam int TIME_WIDTH      = 32;
    localparam int GAP_WIDTH       = 32;
    localparam int STEP_WIDTH      = 7;
    localparam int STEP_OUT_WIDTH  = 8;
    localparam int DELTA_OUT_WIDTH = 16;
    localparam int ACC_WIDTH       = 4;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 3;

    // Gap compare runs at the wider of the time and gap widths.
    localparam int CMP_WIDTH = (TIME_WIDTH > GAP_WIDTH) ? TIME_WIDTH : GAP_WIDTH;
    // Delta sum has headroom for the step before saturation.
    localparam int SUM_WIDTH = DELTA_WIDTH + 2;

    localparam logic signed [SUM_WIDTH-1:0] DELTA_MAX =
        SUM_WIDTH'($signed({1'b0, {(DELTA_WIDTH-1){1'b1}}}));
    localparam logic signed [SUM_WIDTH-1:0] DELTA_MIN =
        SUM_WIDTH'($signed({1'b1, {(DELTA_WIDTH-1){1'b0}}}));

    localparam logic [GAP_WIDTH-1:0] UNITS_PER_MS     = GAP_WIDTH'(240000);
    localparam logic [GAP_WIDTH-1:0] FAST_GAP_RESET   = GAP_WIDTH'(2 * 240000);
    localparam logic [GAP_WIDTH-1:0] MEDIUM_GAP_RESET = GAP_WIDTH'(5 * 240000);
    localparam logic [GAP_WIDTH-1:0] SLOW_GAP_RESET   = GAP_WIDTH'(15 * 240000);
    localparam logic [STEP_WIDTH-1:0] FAST_STEP_RESET   = STEP_WIDTH'(8);
    localparam logic [STEP_WIDTH-1:0] MEDIUM_STEP_RESET = STEP_WIDTH'(4);
    localparam logic [STEP_WIDTH-1:0] SLOW_STEP_RESET   = STEP_WIDTH'(2);
    localparam logic [STEP_WIDTH-1:0] BASE_STEP_RESET   = STEP_WIDTH'(1);

    // Both pins high is the rest position between detents.
    localparam logic [1:0] PINS_IDLE = 2'b11;

    // Move from {previous, current} pin state: +1, -1 or none.
    localparam logic signed [1:0] MOVE_TABLE [16] = '{
         2'sd0,  2'sd1, -2'sd1,  2'sd0,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
         2'sd0, -2'sd1,  2'sd1,  2'sd0
    };

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_FAST_GAP    = 3'd0,
        CFG_MEDIUM_GAP  = 3'd1,
        CFG_SLOW_GAP    = 3'd2,
        CFG_FAST_STEP   = 3'd3,
        CFG_MEDIUM_STEP = 3'd4,
        CFG_SLOW_STEP   = 3'd5,
        CFG_BASE_STEP   = 3'd6
    } cfg_index_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef struct packed {
        op_t                   operation;
        logic                  clk_level;
        logic                  dt_level;
        logic                  button_level;
        logic [31:0]           timestamp;
    } in_item_t;

    typedef struct packed {
        logic signed [DELTA_OUT_WIDTH-1:0] delta_out;
        logic signed [STEP_OUT_WIDTH-1:0]  step_applied;
        logic                              button_pressed;
    } out_item_t;

    typedef struct packed {
        logic [GAP_WIDTH-1:0]  fast_gap;
        logic [GAP_WIDTH-1:0]  medium_gap;
        logic [GAP_WIDTH-1:0]  slow_gap;
        logic [STEP_WIDTH-1:0] fast_step;
        logic [STEP_WIDTH-1:0] medium_step;
        logic [STEP_WIDTH-1:0] slow_step;
        logic [STEP_WIDTH-1:0] base_step;
    } cfg_t;

    typedef struct packed {
        logic                        detent;
        logic                        step_down;
        logic signed [ACC_WIDTH-1:0] acc_next;
    } decode_t;

endpackage

`default_nettype wire

FILE: sv/qdacc_cfg_regs.sv
`default_nettype none

module qdacc_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [qdacc_pkg::CFG_INDEX_WIDTH-1:0] index,
    input  logic [qdacc_pkg::CFG_DATA_WIDTH-1:0]  wr_data,
    output qdacc_pkg::cfg_t                      cfg
);
    import qdacc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(index))
                CFG_FAST_GAP:    cfg_next.fast_gap    = GAP_WIDTH'(wr_data);
                CFG_MEDIUM_GAP:  cfg_next.medium_gap  = GAP_WIDTH'(wr_data);
                CFG_SLOW_GAP:    cfg_next.slow_gap    = GAP_WIDTH'(wr_data);
                CFG_FAST_STEP:   cfg_next.fast_step   = wr_data[STEP_WIDTH-1:0];
                CFG_MEDIUM_STEP: cfg_next.medium_step = wr_data[STEP_WIDTH-1:0];
                CFG_SLOW_STEP:   cfg_next.slow_step   = wr_data[STEP_WIDTH-1:0];
                CFG_BASE_STEP:   cfg_next.base_step   = wr_data[STEP_WIDTH-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_gap    <= FAST_GAP_RESET;
            cfg_reg.medium_gap  <= MEDIUM_GAP_RESET;
            cfg_reg.slow_gap    <= SLOW_GAP_RESET;
            cfg_reg.fast_step   <= FAST_STEP_RESET;
            cfg_reg.medium_step <= MEDIUM_STEP_RESET;
            cfg_reg.slow_step   <= SLOW_STEP_RESET;
            cfg_reg.base_step   <= BASE_STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: sv/qdacc_gray_decode.sv
`default_nettype none

module qdacc_gray_decode (
    input  logic [1:0]                               pins,
    input  logic [1:0]                               prev_pins,
    input  logic signed [qdacc_pkg::ACC_WIDTH-1:0]   acc,
    output qdacc_pkg::decode_t                       dec
);
    import qdacc_pkg::*;

    logic signed [1:0]           move;
    logic signed [ACC_WIDTH:0]   acc_sum;
    logic signed [ACC_WIDTH-1:0] acc_sat;

    always_comb
    begin
        move    = MOVE_TABLE[{prev_pins, pins}];
        acc_sum = (ACC_WIDTH+1)'(acc) + (ACC_WIDTH+1)'(move);

        // The accumulator holds its range rather than wrapping.
        if (acc_sum > (ACC_WIDTH+1)'(signed'(4'sd7)))
        begin
            acc_sat = 4'sd7;
        end
        else if (acc_sum < (ACC_WIDTH+1)'(signed'(-4'sd8)))
        begin
            acc_sat = -4'sd8;
        end
        else
        begin
            acc_sat = acc_sum[ACC_WIDTH-1:0];
        end

        dec.acc_next  = acc;
        dec.detent    = 1'b0;
        dec.step_down = 1'b0;
        if (move != 2'sd0)
        begin
            if (pins == PINS_IDLE)
            begin
                // Landing on rest closes the detent; its direction opposes
                // the sign of the accumulated moves.
                dec.acc_next  = '0;
                dec.detent    = (acc_sat != '0);
                dec.step_down = (acc_sat > 4'sd0);
            end
            else
            begin
                dec.acc_next = acc_sat;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/qdacc_step_select.sv
`default_nettype none

module qdacc_step_select (
    input  logic [qdacc_pkg::TIME_WIDTH-1:0] now,
    input  logic [qdacc_pkg::TIME_WIDTH-1:0] last_time,
    input  qdacc_pkg::cfg_t                  cfg,
    output logic [qdacc_pkg::STEP_WIDTH-1:0] mag
);
    import qdacc_pkg::*;

    logic [TIME_WIDTH-1:0] gap;
    logic [CMP_WIDTH-1:0]  gap_ext;

    always_comb
    begin
        // Time counter wraps, so the difference is taken modulo its width.
        gap     = now - last_time;
        gap_ext = CMP_WIDTH'(gap);
        priority if (gap_ext < CMP_WIDTH'(cfg.fast_gap))
        begin
            mag = cfg.fast_step;
        end
        else if (gap_ext < CMP_WIDTH'(cfg.medium_gap))
        begin
            mag = cfg.medium_step;
        end
        else if (gap_ext < CMP_WIDTH'(cfg.slow_gap))
        begin
            mag = cfg.slow_step;
        end
        else
        begin
            mag = cfg.base_step;
        end
    end

endmodule

`default_nettype wire

FILE: sv/quadrature_decoder_with_acceleration_core.sv
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-------------------------------
//  in      | input     | in_valid / in_ready | in_data  (operation, pins, time)
//  out     | output    | out_valid/out_ready | out_data (delta, step, button)
//  cfg     | input     | cfg_wr_en           | cfg_index, cfg_wr_data
//
//  Each transaction passes an input register and a result register, and one
//  transaction is accepted every cycle while out_ready holds.
//  The decoder state updates in the same cycle the result register loads, so
//  back-to-back samples see each other's effect without bubbles.
//  rst_n sets the pin history to rest and clears accumulator, detent time, delta and valid flags.
//  A stalled output holds its result; the input register keeps one more
//  transaction and in_ready drops only when both stages are full.
`default_nettype none
`include "quadrature_decoder_with_acceleration_core_assert.svh"

module quadrature_decoder_with_acceleration_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  qdacc_pkg::in_item_t                  in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output qdacc_pkg::out_item_t                 out_data,
    input  logic                                 cfg_wr_en,
    input  logic [qdacc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [qdacc_pkg::CFG_DATA_WIDTH-1:0]  cfg_wr_data
);
    import qdacc_pkg::*;

    // Handshake and pipeline control.
    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      in_fire;
    logic      out_free;
    logic      work_fire;

    // Decoder state.
    logic [1:0]                    prev_pins_reg;
    logic [1:0]                    prev_pins_next;
    logic signed [ACC_WIDTH-1:0]   acc_reg;
    logic signed [ACC_WIDTH-1:0]   acc_next;
    logic [TIME_WIDTH-1:0]         last_time_reg;
    logic [TIME_WIDTH-1:0]         last_time_next;
    logic signed [DELTA_WIDTH-1:0] delta_total_reg;
    logic signed [DELTA_WIDTH-1:0] delta_total_next;

    // Work on the item held in the input register.
    cfg_t                              cfg;
    decode_t                           dec;
    logic [1:0]                        cur_pins;
    logic [TIME_WIDTH-1:0]             now;
    logic [STEP_WIDTH-1:0]             mag;
    logic signed [STEP_OUT_WIDTH-1:0]  step_val;
    logic signed [SUM_WIDTH-1:0]       delta_sum;
    logic signed [DELTA_OUT_WIDTH-1:0] delta_view;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || out_free;
    assign in_fire   = in_valid && in_ready;
    assign work_fire = s1_valid_reg && out_free;

    assign cur_pins = {s1_item_reg.clk_level, s1_item_reg.dt_level};
    assign now      = TIME_WIDTH'(s1_item_reg.timestamp);

    qdacc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_wr_en),
        .index   (cfg_index),
        .wr_data (cfg_wr_data),
        .cfg     (cfg)
    );

    qdacc_gray_decode u_gray_decode (
        .pins      (cur_pins),
        .prev_pins (prev_pins_reg),
        .acc       (acc_reg),
        .dec       (dec)
    );

    qdacc_step_select u_step_select (
        .now       (now),
        .last_time (last_time_reg),
        .cfg       (cfg),
        .mag       (mag)
    );

    always_comb
    begin
        // Signed step for a detent: magnitude from the speed bands, sign
        // from the detent direction.
        if (dec.step_down)
        begin
            step_val = -$signed({1'b0, mag});
        end
        else
        begin
            step_val = $signed({1'b0, mag});
        end

        delta_sum  = SUM_WIDTH'(delta_total_reg) + SUM_WIDTH'(step_val);
        // The read result carries the low bits of the sign-extended total.
        delta_view = DELTA_OUT_WIDTH'(delta_total_reg);

        prev_pins_next   = prev_pins_reg;
        acc_next         = acc_reg;
        last_time_next   = last_time_reg;
        delta_total_next = delta_total_reg;

        out_item_next.delta_out      = '0;
        out_item_next.step_applied   = '0;
        out_item_next.button_pressed = !s1_item_reg.button_level;

        if (work_fire)
        begin
            unique case (s1_item_reg.operation)
                OP_READ:
                begin
                    out_item_next.delta_out = delta_view;
                    delta_total_next        = '0;
                end
                OP_SAMPLE:
                begin
                    prev_pins_next = cur_pins;
                    acc_next       = dec.acc_next;
                    if (dec.detent)
                    begin
                        out_item_next.step_applied = step_val;
                        last_time_next             = now;
                        // The running delta clamps at its signed limits.
                        priority if (delta_sum > DELTA_MAX)
                        begin
                            delta_total_next = DELTA_MAX[DELTA_WIDTH-1:0];
                        end
                        else if (delta_sum < DELTA_MIN)
                        begin
                            delta_total_next = DELTA_MIN[DELTA_WIDTH-1:0];
                        end
                        else
                        begin
                            delta_total_next = delta_sum[DELTA_WIDTH-1:0];
                        end
                    end
                end
                default:
                begin
                    delta_total_next = delta_total_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            prev_pins_reg   <= PINS_IDLE;
            acc_reg         <= '0;
            last_time_reg   <= '0;
            delta_total_reg <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            prev_pins_reg   <= prev_pins_next;
            acc_reg         <= acc_next;
            last_time_reg   <= last_time_next;
            delta_total_reg <= delta_total_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_data;
        end
        if (work_fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // A read leaves the running delta cleared for the next transaction.
    `QDACC_ASSERT(a_read_clears_delta,
        work_fire && (s1_item_reg.operation == OP_READ) |=> delta_total_reg == '0)

    // A pin sample always becomes the new pin history.
    `QDACC_ASSERT(a_pins_tracked,
        work_fire && (s1_item_reg.operation == OP_SAMPLE) |=> prev_pins_reg == $past(cur_pins))

    // A result never carries both a read delta and a step.
    `QDACC_ASSERT(a_read_or_step,
        out_valid_reg && (out_item_reg.delta_out != '0) |-> out_item_reg.step_applied == '0)

    // Nothing reaches the output stage without an item in the input register.
    `QDACC_ASSERT_ALWAYS(a_out_from_stage,
        rst_n && !$past(s1_valid_reg) && $past(rst_n) && !$past(out_valid_reg) |-> !out_valid_reg)

endmodule

`default_nettype wire
